>>> rtl/pccrc_pkg.sv
// Package for the per-context class run coalescer.
// Holds widths, function codes and the record types used between the modules.
// No dependencies.
package pccrc_pkg;

    // Context table geometry and field widths.
    localparam int NUM_CONTEXTS = 64;
    localparam int CTX_W        = 6;
    localparam int CLASS_BITS   = 4;
    localparam int LEN_W        = 16;
    localparam int PC_W         = 64;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // Reset value of the run limit register.
    localparam logic [LEN_W-1:0] RUN_LIMIT_RST = 16'd64;
    localparam logic [LEN_W-1:0] LEN_MAX       = '1;

    // Event function codes.
    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_FLUSH   = 1'b1;

    // One entry of the context table.
    typedef struct packed {
        logic [CLASS_BITS-1:0] cls;
        logic [LEN_W-1:0]      len;
        logic [PC_W-1:0]       pc;
    } entry_t;

    // One emitted run.
    typedef struct packed {
        logic [CTX_W-1:0]      ctx;
        logic [CLASS_BITS-1:0] cls;
        logic [LEN_W-1:0]      len;
        logic [PC_W-1:0]       pc;
        logic                  last;
    } result_t;

    // The zero, one or two runs produced by one event.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } emit_t;

endpackage

>>> rtl/per_context_class_run_coalescer.sv
// Per-context class run coalescer, top level.
// A result passes the update stage registers and the result queue before transfer.
// Throughput: one event per cycle while the result queue has room, paced by the
// single context-table read-modify-write per event, with the last write forwarded to the next read.
// Reset clears the pipeline, the result queue and the per-context written
// bits, and loads the run limit with 64; no clearing pass over the table.
module per_context_class_run_coalescer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration: run limit.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pccrc_pkg::LEN_W-1:0]           cfg_data,
    // Event stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: ctx_id [5:0], insn_pc [69:6], instr_class [73:70], zero fill.
    input  logic [pccrc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: func [0].
    input  logic                                  s_tuser,
    // Run stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: out_ctx [5:0], run_class [9:6], run_length [25:10],
    // run_pc [89:26], zero fill.
    output logic [pccrc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tlast
);

    logic [pccrc_pkg::LEN_W-1:0]        run_limit_reg;
    logic                               s_xfer;
    logic                               room;
    logic                               busy;
    logic [pccrc_pkg::CTX_W-1:0]        in_ctx;
    logic [pccrc_pkg::PC_W-1:0]         in_pc;
    logic [pccrc_pkg::CLASS_BITS-1:0]   in_class;
    logic                               ram_we;
    logic [pccrc_pkg::CTX_W-1:0]        ram_waddr;
    pccrc_pkg::entry_t                  ram_wdata;
    pccrc_pkg::entry_t                  ram_rdata;
    pccrc_pkg::emit_t                   emit;
    pccrc_pkg::result_t                 out_run;

    // Input field unpacking.
    assign in_ctx   = s_tdata[5:0];
    assign in_pc    = s_tdata[69:6];
    assign in_class = s_tdata[73:70];

    assign s_tready  = room;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Run limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= pccrc_pkg::RUN_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            run_limit_reg <= cfg_data;
        end
    end

    // Context table, read on the event transfer.
    pccrc_ram #(
        .WIDTH ($bits(pccrc_pkg::entry_t)),
        .DEPTH (pccrc_pkg::NUM_CONTEXTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_ctx),
        .rdata (ram_rdata)
    );

    // Run update stage.
    pccrc_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_xfer),
        .in_func   (s_tuser),
        .in_ctx    (in_ctx),
        .in_pc     (in_pc),
        .in_class  (in_class),
        .run_limit (run_limit_reg),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .busy      (busy),
        .emit      (emit)
    );

    // Result queue.
    pccrc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .busy      (busy),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_run)
    );

    // Output packing.
    assign m_tdata = {6'd0, out_run.pc, out_run.len, out_run.cls, out_run.ctx};
    assign m_tlast = out_run.last;

endmodule

>>> rtl/pccrc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
// No dependencies.
module pccrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array and read register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pccrc_update.sv
// Read-modify-write stage of the coalescer: merges an event into its context's
// open run, decides which runs are emitted and writes the entry back.
// Depends on pccrc_pkg.
module pccrc_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_func,
    input  logic [pccrc_pkg::CTX_W-1:0]         in_ctx,
    input  logic [pccrc_pkg::PC_W-1:0]          in_pc,
    input  logic [pccrc_pkg::CLASS_BITS-1:0]    in_class,
    input  logic [pccrc_pkg::LEN_W-1:0]         run_limit,
    input  pccrc_pkg::entry_t                   ram_rdata,
    output logic                                ram_we,
    output logic [pccrc_pkg::CTX_W-1:0]         ram_waddr,
    output pccrc_pkg::entry_t                   ram_wdata,
    output logic                                busy,
    output pccrc_pkg::emit_t                    emit
);

    // Event held while its table entry is read.
    logic                                s1_valid_reg;
    logic                                s1_func_reg;
    logic [pccrc_pkg::CTX_W-1:0]         s1_ctx_reg;
    logic [pccrc_pkg::PC_W-1:0]          s1_pc_reg;
    logic [pccrc_pkg::CLASS_BITS-1:0]    s1_class_reg;

    // Copy of the entry written at the last edge, for forwarding.
    logic                                fwd_valid_reg;
    logic [pccrc_pkg::CTX_W-1:0]         fwd_ctx_reg;
    pccrc_pkg::entry_t                   fwd_entry_reg;

    // One bit per context: set once the entry has been written.
    logic [pccrc_pkg::NUM_CONTEXTS-1:0]  written_reg;

    pccrc_pkg::entry_t                   cur;
    pccrc_pkg::entry_t                   upd;
    logic                                fwd_hit;
    logic                                emit_old;
    logic                                emit_new;
    logic [pccrc_pkg::LEN_W-1:0]         base_len;
    logic [pccrc_pkg::LEN_W-1:0]         new_len;
    pccrc_pkg::result_t                  old_run;
    pccrc_pkg::result_t                  new_run;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            fwd_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                written_reg[s1_ctx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_func_reg  <= in_func;
            s1_ctx_reg   <= in_ctx;
            s1_pc_reg    <= in_pc;
            s1_class_reg <= in_class;
        end
        fwd_ctx_reg   <= s1_ctx_reg;
        fwd_entry_reg <= upd;
    end

    // Current entry: forwarded write, table contents, or an empty run.
    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_ctx_reg == s1_ctx_reg);
        if (fwd_hit)
        begin
            cur = fwd_entry_reg;
        end
        else
        begin
            cur = ram_rdata;
            if (!written_reg[s1_ctx_reg])
            begin
                cur.len = '0;
            end
        end
    end

    // Run update and emission decisions.
    always_comb
    begin
        emit_old = 1'b0;
        emit_new = 1'b0;
        base_len = cur.len;
        new_len  = cur.len;
        upd      = cur;
        if (s1_func_reg == pccrc_pkg::FUNC_FLUSH)
        begin
            emit_old = (cur.len != '0);
            upd.len  = '0;
        end
        else
        begin
            emit_old = (cur.len != '0) && (cur.cls != s1_class_reg);
            base_len = emit_old ? '0 : cur.len;
            new_len  = (base_len == pccrc_pkg::LEN_MAX) ? base_len
                                                         : base_len + 1'b1;
            emit_new = (new_len >= run_limit);
            upd.cls  = s1_class_reg;
            upd.pc   = s1_pc_reg;
            upd.len  = emit_new ? '0 : new_len;
        end
    end

    // Runs leaving this event.
    always_comb
    begin
        old_run.ctx  = s1_ctx_reg;
        old_run.cls  = cur.cls;
        old_run.len  = cur.len;
        old_run.pc   = cur.pc;
        old_run.last = !emit_new;

        new_run.ctx  = s1_ctx_reg;
        new_run.cls  = s1_class_reg;
        new_run.len  = new_len;
        new_run.pc   = s1_pc_reg;
        new_run.last = 1'b1;

        emit.second = new_run;
        if (!s1_valid_reg)
        begin
            emit.cnt   = 2'd0;
            emit.first = new_run;
        end
        else if (emit_old && emit_new)
        begin
            emit.cnt   = 2'd2;
            emit.first = old_run;
        end
        else if (emit_old)
        begin
            emit.cnt   = 2'd1;
            emit.first = old_run;
        end
        else if (emit_new)
        begin
            emit.cnt   = 2'd1;
            emit.first = new_run;
        end
        else
        begin
            emit.cnt   = 2'd0;
            emit.first = new_run;
        end
    end

    assign ram_we    = s1_valid_reg;
    assign ram_waddr = s1_ctx_reg;
    assign ram_wdata = upd;
    assign busy      = s1_valid_reg;

endmodule

>>> rtl/pccrc_out_fifo.sv
// Result queue of the coalescer: takes up to two runs per cycle, hands out one
// per transfer, and reports whether room remains for the events in flight.
// Depends on pccrc_pkg.
module pccrc_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  pccrc_pkg::emit_t   emit,
    input  logic               busy,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output pccrc_pkg::result_t out_data
);

    pccrc_pkg::result_t                entries_reg [pccrc_pkg::FIFO_DEPTH];
    logic [pccrc_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [pccrc_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [pccrc_pkg::FIFO_CW-1:0]     count_reg;
    logic [pccrc_pkg::FIFO_CW-1:0]     count_next;
    logic [pccrc_pkg::FIFO_CW-1:0]     need;
    logic [pccrc_pkg::FIFO_AW-1:0]     wr_ptr_inc;
    logic                              pop;

    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign count_next = count_reg + pccrc_pkg::FIFO_CW'(emit.cnt)
                        - pccrc_pkg::FIFO_CW'(pop);

    // Room for the runs of the event in the update stage and of a new event.
    assign need = count_reg + (busy ? pccrc_pkg::FIFO_CW'(4) : pccrc_pkg::FIFO_CW'(2));
    assign room = (need <= pccrc_pkg::FIFO_CW'(pccrc_pkg::FIFO_DEPTH));

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + pccrc_pkg::FIFO_AW'(emit.cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (emit.cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= emit.first;
        end
        if (emit.cnt == 2'd2)
        begin
            entries_reg[wr_ptr_inc] <= emit.second;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the per-context class run coalescer.
// Drives retirement and flush events, predicts the emitted runs per context and
// checks every run transfer. Depends on pccrc_pkg and the coalescer top level.
`timescale 1ns / 100ps

module testbench;

    import pccrc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 480;

    typedef struct {
        logic                  func;
        logic [CTX_W-1:0]      ctx;
        logic [PC_W-1:0]       pc;
        logic [CLASS_BITS-1:0] cls;
    } insn_event_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LEN_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Stimulus and scoreboard state.
    insn_event_t      event_queue[$];
    insn_event_t      cur_event;
    result_t          expected_runs[$];
    int unsigned      events_issued = 0;
    int unsigned      events_taken = 0;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    logic             hold_go = 1'b0;
    logic             hold_on = 1'b0;

    // Shadow of the context table and the run limit.
    logic [CLASS_BITS-1:0] shadow_cls [NUM_CONTEXTS];
    logic [LEN_W-1:0]      shadow_len [NUM_CONTEXTS];
    logic [PC_W-1:0]       shadow_pc  [NUM_CONTEXTS];
    logic [LEN_W-1:0]      run_limit = RUN_LIMIT_RST;

    per_context_class_run_coalescer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Snapshot of the open run of a context, as it would be emitted.
    function automatic result_t open_run(input logic [CTX_W-1:0] c, input logic is_last);
        result_t r;
        r.ctx  = c;
        r.cls  = shadow_cls[c];
        r.len  = shadow_len[c];
        r.pc   = shadow_pc[c];
        r.last = is_last;
        return r;
    endfunction

    // Applies one accepted event to the shadow table and queues the runs it closes.
    task automatic coalesce_event(input insn_event_t ev);
        result_t old_run;
        logic    class_change;
        logic    at_limit;
        if (ev.func == FUNC_FLUSH)
        begin
            if (shadow_len[ev.ctx] != 0)
            begin
                expected_runs.push_back(open_run(ev.ctx, 1'b1));
                shadow_len[ev.ctx] = '0;
            end
        end
        else
        begin
            class_change = (shadow_len[ev.ctx] != 0) && (shadow_cls[ev.ctx] != ev.cls);
            old_run = open_run(ev.ctx, 1'b1);
            if (class_change)
                shadow_len[ev.ctx] = '0;
            shadow_cls[ev.ctx] = ev.cls;
            shadow_pc[ev.ctx]  = ev.pc;
            if (shadow_len[ev.ctx] != LEN_MAX)
                shadow_len[ev.ctx] = shadow_len[ev.ctx] + 1'b1;
            at_limit = (shadow_len[ev.ctx] >= run_limit);
            // The displaced run is only marked last when the new one stays open.
            if (class_change)
            begin
                old_run.last = !at_limit;
                expected_runs.push_back(old_run);
            end
            if (at_limit)
            begin
                expected_runs.push_back(open_run(ev.ctx, 1'b1));
                shadow_len[ev.ctx] = '0;
            end
        end
    endtask

    task automatic add_event(input logic func, input logic [CTX_W-1:0] c,
                             input logic [PC_W-1:0] pc, input logic [CLASS_BITS-1:0] cls);
        insn_event_t ev;
        ev.func = func;
        ev.ctx  = c;
        ev.pc   = pc;
        ev.cls  = cls;
        event_queue.push_back(ev);
        events_issued++;
    endtask

    function automatic logic [PC_W-1:0] random_pc();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed runs on a few busy contexts, with some noise mixed in.
    task automatic add_random_items(input int unsigned count);
        int unsigned      added;
        int unsigned      run_len;
        int unsigned      max_len;
        logic [CTX_W-1:0] c;
        logic [CLASS_BITS-1:0] cls;
        added = 0;
        max_len = (run_limit < 24) ? run_limit + 2 : 24;
        while (added < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                c = ($urandom_range(99) < 70) ? CTX_W'($urandom_range(3))
                                              : CTX_W'($urandom_range(NUM_CONTEXTS - 1));
                cls = CLASS_BITS'($urandom);
                run_len = $urandom_range(1, max_len);
                repeat (run_len)
                    add_event(FUNC_COMPUTE, c, random_pc(), cls);
                added += run_len;
                if ($urandom_range(99) < 30)
                begin
                    add_event(FUNC_FLUSH, c, random_pc(), CLASS_BITS'($urandom));
                    added++;
                end
            end
            else
            begin
                add_event(1'($urandom), CTX_W'($urandom), random_pc(), CLASS_BITS'($urandom));
                added++;
            end
        end
    endtask

    // Waits until every event has been taken and every run has arrived,
    // then lets the pipeline drain of events that close no run.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (events_taken != events_issued || expected_runs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_run_limit(input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        run_limit = value;
    endtask

    // Event driver: holds an offered event until its transfer completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                coalesce_event(cur_event);
                events_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_event = event_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, cur_event.cls, cur_event.pc, cur_event.ctx};
                    s_tuser  <= cur_event.func;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Run monitor: checks each run transfer against the oldest expected run.
    always @(posedge clk or negedge rst_n)
    begin : run_monitor
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("unexpected run: ctx %0d class %0d length %0d",
                           m_tdata[5:0], m_tdata[9:6], m_tdata[25:10]);
                    error_count++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (m_tdata[5:0] !== want.ctx)
                    begin
                        $error("out_ctx: expected %0d, got %0d", want.ctx, m_tdata[5:0]);
                        error_count++;
                    end
                    if (m_tdata[9:6] !== want.cls)
                    begin
                        $error("run_class: expected %0d, got %0d", want.cls, m_tdata[9:6]);
                        error_count++;
                    end
                    if (m_tdata[25:10] !== want.len)
                    begin
                        $error("run_length: expected %0d, got %0d", want.len, m_tdata[25:10]);
                        error_count++;
                    end
                    if (m_tdata[89:26] !== want.pc)
                    begin
                        $error("run_pc: expected %h, got %h", want.pc, m_tdata[89:26]);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so that the result queue fills and the input stalls.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        for (int i = 0; i < NUM_CONTEXTS; i++)
        begin
            shadow_cls[i] = '0;
            shadow_len[i] = '0;
            shadow_pc[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events at the reset limit: empty flush, field extremes,
        // a class change and flushes of non-empty and empty runs.
        add_event(FUNC_FLUSH, 6'd0, '0, '0);
        add_event(FUNC_COMPUTE, 6'd0, '0, 4'd0);
        add_event(FUNC_COMPUTE, 6'd0, '1, 4'd0);
        add_event(FUNC_COMPUTE, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA, 4'd15);
        add_event(FUNC_COMPUTE, 6'd0, 64'h5555_5555_5555_5555, 4'd15);
        add_event(FUNC_FLUSH, 6'd0, '0, '0);
        add_event(FUNC_FLUSH, 6'd0, '1, '1);
        add_event(FUNC_FLUSH, 6'd63, '0, '0);
        repeat (5)
            add_event(FUNC_COMPUTE, 6'd5, random_pc(), 4'd3);
        wait_idle();

        // Limit lowered below an open length: the next event closes the run.
        write_run_limit(16'd3);
        add_event(FUNC_COMPUTE, 6'd5, random_pc(), 4'd3);
        add_event(FUNC_COMPUTE, 6'd7, random_pc(), 4'd1);
        add_event(FUNC_COMPUTE, 6'd7, random_pc(), 4'd1);
        wait_idle();

        // Class change where the new event also closes its run at the limit.
        write_run_limit(16'd1);
        add_event(FUNC_COMPUTE, 6'd7, random_pc(), 4'd2);
        add_event(FUNC_COMPUTE, 6'd9, random_pc(), 4'd4);
        wait_idle();

        // Random phases with changing handshake pressure and run limits.
        send_idle_pct <= 7;
        recv_idle_pct <= 74;
        write_run_limit(16'd4);
        add_random_items(PHASE_ITEMS);
        wait_idle();

        send_idle_pct <= 74;
        recv_idle_pct <= 7;
        write_run_limit(LEN_MAX);
        add_random_items(PHASE_ITEMS);
        wait_idle();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_run_limit(16'd1);
        hold_go <= 1'b1;
        add_random_items(PHASE_ITEMS);
        wait_idle();

        write_run_limit(LEN_W'($urandom_range(2, 40)));
        add_random_items(PHASE_ITEMS);
        wait_idle();

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
